FILE: rtl/core/dual_cpu_mailbox_fifo_sync_unit_assert.svh
// ----------------------------------------------------------------------------
// Mailbox assertion macros
// Short forms for the concurrent checks at the end of the mailbox top level.
// ----------------------------------------------------------------------------
`ifndef DUAL_CPU_MAILBOX_FIFO_SYNC_UNIT_ASSERT_SVH
`define DUAL_CPU_MAILBOX_FIFO_SYNC_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define DCMFS_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define DCMFS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/dcmfs_pkg.sv
// ----------------------------------------------------------------------------
// Mailbox package
// Operation codes, interrupt kinds, register bit positions and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dcmfs_pkg;

   localparam int DATA_W            = 32;
   localparam int MBX_DEPTH_DEFAULT = 16;

   // Bus operations.
   localparam logic [2:0] OP_SYNC_READ  = 3'd0;
   localparam logic [2:0] OP_SYNC_WRITE = 3'd1;
   localparam logic [2:0] OP_CTRL_READ  = 3'd2;
   localparam logic [2:0] OP_CTRL_WRITE = 3'd3;
   localparam logic [2:0] OP_SEND       = 3'd4;
   localparam logic [2:0] OP_RECEIVE    = 3'd5;

   // Interrupt kinds.
   localparam logic [1:0] IRQ_NONE        = 2'd0;
   localparam logic [1:0] IRQ_SYNC        = 2'd1;
   localparam logic [1:0] IRQ_SEND_EMPTY  = 2'd2;
   localparam logic [1:0] IRQ_RECV_FILLED = 2'd3;

   // Sync register bit positions.
   localparam int SYNC_PEER_LSB  = 0;
   localparam int SYNC_OWN_LSB   = 8;
   localparam int SYNC_IRQ_REQ   = 13;
   localparam int SYNC_ACCEPT    = 14;

   // Control register bit positions.
   localparam int CTL_SEND_EMPTY = 0;
   localparam int CTL_SEND_FULL  = 1;
   localparam int CTL_SEND_IE    = 2;
   localparam int CTL_SEND_CLEAR = 3;
   localparam int CTL_RECV_EMPTY = 8;
   localparam int CTL_RECV_FULL  = 9;
   localparam int CTL_RECV_IE    = 10;
   localparam int CTL_ERROR      = 14;
   localparam int CTL_ENABLE     = 15;

   // Per-side flag set.
   typedef struct packed {
      logic enable;
      logic error;
      logic recv_ie;
      logic send_ie;
      logic accept;
   } side_flags_type;

endpackage

FILE: rtl/core/dcmfs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcmfs_ram #(
   parameter int WIDTH = dcmfs_pkg::DATA_W,
   parameter int DEPTH = 2 * dcmfs_pkg::MBX_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/dual_cpu_mailbox_fifo_sync_unit.sv
// ----------------------------------------------------------------------------
// Dual processor mailbox
// Sync register and one word queue per direction between two processors.
// ----------------------------------------------------------------------------
// Usage: each request transfer on the req_ channel is one bus access by the
// side given in req_side, performing one of six operations (sync read/write,
// control read/write, send, receive). Every request yields exactly one
// response transfer on the rsp_ channel, carrying the read data and at most
// one edge interrupt, given as a kind and a target processor.
// Queue 0 carries words from the main side to the secondary side, queue 1 the
// other way. Both queues share one RAM, each queue taking one half of it.
// The response is registered and appears in the cycle after the request is
// taken. A receive that pops a word reads the RAM first, through the RAM read
// register and then the response register, and the request channel is stalled
// while that read is in flight. One transfer is taken per cycle while the
// response does not stall and no popping receive is waiting for its word.
// The response register lets a new request be taken in the same cycle as the
// waiting response is taken. While the receiver stalls with a response held,
// req_stall is raised and no request is taken.
// Reset (synchronous) empties both queues, clears all flags, sync outputs and
// the last words read; the RAM contents are not cleared, as an entry is never
// read before it is written.
`timescale 1ns / 1ps

module dual_cpu_mailbox_fifo_sync_unit #(
   parameter int MBX_DEPTH = dcmfs_pkg::MBX_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_operation,
   input  logic        req_side,
   input  logic [31:0] req_write_data,
   // Response channel.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_data,
   output logic [1:0]  rsp_irq_kind,
   output logic        rsp_irq_target
);

   localparam int PTR_W  = (MBX_DEPTH > 1) ? $clog2(MBX_DEPTH) : 1;
   localparam int CNT_W  = $clog2(MBX_DEPTH + 1);
   localparam int ADDR_W = PTR_W + 1;
   localparam int RAM_DEPTH = 2 << PTR_W;
   localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(MBX_DEPTH);
   localparam logic [PTR_W-1:0] HEAD_LAST  = PTR_W'(MBX_DEPTH - 1);
   localparam logic [PTR_W:0]   SLOT_WRAP  = (PTR_W + 1)'(MBX_DEPTH);

   // Queue state, per queue (index is the sending side).
   logic [PTR_W-1:0]            head_ff  [2];
   logic [PTR_W-1:0]            head_in  [2];
   logic [CNT_W-1:0]            count_ff [2];
   logic [CNT_W-1:0]            count_in [2];
   // Per-side state.
   logic [3:0]                  sync_ff  [2];
   logic [3:0]                  sync_in  [2];
   dcmfs_pkg::side_flags_type   flags_ff [2];
   dcmfs_pkg::side_flags_type   flags_in [2];
   logic [31:0]                 last_ff  [2];
   logic [31:0]                 last_in  [2];

   // Pop in flight and response register.
   logic        pending_ff, pending_in;
   logic        pend_side_ff, pend_side_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_read_data_ff, rsp_read_data_in;
   logic [1:0]  rsp_irq_kind_ff, rsp_irq_kind_in;
   logic        rsp_irq_target_ff, rsp_irq_target_in;

   // RAM access.
   logic              ram_we, ram_re;
   logic [ADDR_W-1:0] ram_wa, ram_ra;
   logic [31:0]       ram_rd_data;

   logic              req_accept;
   logic              s, p;
   logic              pop;
   logic [PTR_W:0]    slot_sum;
   logic [PTR_W:0]    slot;
   logic [31:0]       acc_rd;
   logic [1:0]        acc_kind;
   logic              acc_target;

   // A request is taken when no pop is in flight and the response register
   // is free or is being emptied in this cycle.
   assign req_stall  = pending_ff || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;

   assign s = req_side;
   assign p = ~req_side;

   // Tail slot of the sending side's queue; head and count are both below
   // the depth when a word is written, so one subtraction wraps it.
   assign slot_sum = {1'b0, head_ff[s]} + {1'b0, count_ff[s][PTR_W-1:0]};
   assign slot     = (slot_sum >= SLOT_WRAP) ? (slot_sum - SLOT_WRAP) : slot_sum;

   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      sync_in      = sync_ff;
      flags_in     = flags_ff;
      last_in      = last_ff;
      acc_rd       = '0;
      acc_kind     = dcmfs_pkg::IRQ_NONE;
      acc_target   = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_wa       = {s, slot[PTR_W-1:0]};
      ram_ra       = {p, head_ff[p]};
      pop          = 1'b0;

      if (req_accept) begin
         unique case (req_operation)
            dcmfs_pkg::OP_SYNC_READ: begin
               acc_rd[dcmfs_pkg::SYNC_PEER_LSB +: 4] = sync_ff[p];
               acc_rd[dcmfs_pkg::SYNC_OWN_LSB +: 4]  = sync_ff[s];
               acc_rd[dcmfs_pkg::SYNC_ACCEPT]        = flags_ff[s].accept;
            end
            dcmfs_pkg::OP_SYNC_WRITE: begin
               sync_in[s]         = req_write_data[dcmfs_pkg::SYNC_OWN_LSB +: 4];
               flags_in[s].accept = req_write_data[dcmfs_pkg::SYNC_ACCEPT];
               // The peer only sees the request if it has opted in.
               if (req_write_data[dcmfs_pkg::SYNC_IRQ_REQ] && flags_ff[p].accept) begin
                  acc_kind   = dcmfs_pkg::IRQ_SYNC;
                  acc_target = p;
               end
            end
            dcmfs_pkg::OP_CTRL_READ: begin
               acc_rd[dcmfs_pkg::CTL_SEND_EMPTY] = (count_ff[s] == '0);
               acc_rd[dcmfs_pkg::CTL_SEND_FULL]  = (count_ff[s] == COUNT_FULL);
               acc_rd[dcmfs_pkg::CTL_SEND_IE]    = flags_ff[s].send_ie;
               acc_rd[dcmfs_pkg::CTL_RECV_EMPTY] = (count_ff[p] == '0);
               acc_rd[dcmfs_pkg::CTL_RECV_FULL]  = (count_ff[p] == COUNT_FULL);
               acc_rd[dcmfs_pkg::CTL_RECV_IE]    = flags_ff[s].recv_ie;
               acc_rd[dcmfs_pkg::CTL_ERROR]      = flags_ff[s].error;
               acc_rd[dcmfs_pkg::CTL_ENABLE]     = flags_ff[s].enable;
            end
            dcmfs_pkg::OP_CTRL_WRITE: begin
               flags_in[s].send_ie = req_write_data[dcmfs_pkg::CTL_SEND_IE];
               flags_in[s].recv_ie = req_write_data[dcmfs_pkg::CTL_RECV_IE];
               flags_in[s].enable  = req_write_data[dcmfs_pkg::CTL_ENABLE];
               flags_in[s].error   = flags_ff[s].error
                                     && !req_write_data[dcmfs_pkg::CTL_ERROR];
               if (req_write_data[dcmfs_pkg::CTL_SEND_CLEAR]) begin
                  head_in[s]  = '0;
                  count_in[s] = '0;
                  if ((count_ff[s] != '0) && req_write_data[dcmfs_pkg::CTL_SEND_IE]) begin
                     acc_kind   = dcmfs_pkg::IRQ_SEND_EMPTY;
                     acc_target = s;
                  end
               end
            end
            dcmfs_pkg::OP_SEND: begin
               if (flags_ff[s].enable) begin
                  if (count_ff[s] == COUNT_FULL) begin
                     flags_in[s].error = 1'b1;
                  end else begin
                     ram_we      = 1'b1;
                     count_in[s] = count_ff[s] + CNT_W'(1);
                     if ((count_ff[s] == '0) && flags_ff[p].recv_ie) begin
                        acc_kind   = dcmfs_pkg::IRQ_RECV_FILLED;
                        acc_target = p;
                     end
                  end
               end
            end
            dcmfs_pkg::OP_RECEIVE: begin
               if (!flags_ff[s].enable) begin
                  acc_rd = last_ff[s];
               end else if (count_ff[p] == '0) begin
                  flags_in[s].error = 1'b1;
                  acc_rd            = last_ff[s];
               end else begin
                  // Word arrives from the RAM in the next cycle.
                  pop         = 1'b1;
                  ram_re      = 1'b1;
                  head_in[p]  = (head_ff[p] == HEAD_LAST) ? '0
                                : head_ff[p] + PTR_W'(1);
                  count_in[p] = count_ff[p] - CNT_W'(1);
                  if ((count_ff[p] == CNT_W'(1)) && flags_ff[p].send_ie) begin
                     acc_kind   = dcmfs_pkg::IRQ_SEND_EMPTY;
                     acc_target = p;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (pending_ff) begin
         last_in[pend_side_ff] = ram_rd_data;
      end
   end

   always_comb begin
      pending_in        = req_accept && pop;
      pend_side_in      = req_accept ? s : pend_side_ff;
      rsp_read_data_in  = rsp_read_data_ff;
      rsp_irq_kind_in   = rsp_irq_kind_ff;
      rsp_irq_target_in = rsp_irq_target_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      if (req_accept) begin
         rsp_read_data_in  = acc_rd;
         rsp_irq_kind_in   = acc_kind;
         rsp_irq_target_in = acc_target;
         rsp_valid_in      = !pop;
      end else if (pending_ff) begin
         rsp_read_data_in  = ram_rd_data;
         rsp_valid_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff[0]   <= '0;
         head_ff[1]   <= '0;
         count_ff[0]  <= '0;
         count_ff[1]  <= '0;
         sync_ff[0]   <= '0;
         sync_ff[1]   <= '0;
         flags_ff[0]  <= '0;
         flags_ff[1]  <= '0;
         last_ff[0]   <= '0;
         last_ff[1]   <= '0;
         pending_ff   <= 1'b0;
         pend_side_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         sync_ff      <= sync_in;
         flags_ff     <= flags_in;
         last_ff      <= last_in;
         pending_ff   <= pending_in;
         pend_side_ff <= pend_side_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_read_data_ff  <= rsp_read_data_in;
      rsp_irq_kind_ff   <= rsp_irq_kind_in;
      rsp_irq_target_ff <= rsp_irq_target_in;
   end

   dcmfs_ram #(
      .WIDTH (dcmfs_pkg::DATA_W),
      .DEPTH (RAM_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (req_write_data),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_read_data_ff;
   assign rsp_irq_kind   = rsp_irq_kind_ff;
   assign rsp_irq_target = rsp_irq_target_ff;

   // Checks.
`include "dual_cpu_mailbox_fifo_sync_unit_assert.svh"

   `DCMFS_ASSERT_NEXT(a_pop_completes, clock, reset, pending_ff, !pending_ff && rsp_valid_ff, "pop did not complete in one cycle")
   `DCMFS_ASSERT_ALWAYS(a_no_take_during_pop, clock, reset, !(pending_ff && req_accept), "request taken while a pop was in flight")
   `DCMFS_ASSERT_ALWAYS(a_count_bound, clock, reset, (count_ff[0] <= COUNT_FULL) && (count_ff[1] <= COUNT_FULL), "queue count beyond depth")
   `DCMFS_ASSERT_ALWAYS(a_quiet_target, clock, reset, !(rsp_valid_ff && (rsp_irq_kind_ff == dcmfs_pkg::IRQ_NONE) && rsp_irq_target_ff), "interrupt target set without a kind")

endmodule

FILE: test/dual_cpu_mailbox_fifo_sync_unit_tb.sv
// ----------------------------------------------------------------------------
// Dual processor mailbox testbench
// Drives bus accesses from both sides through the request channel and checks
// every response against the directed table or a cycle-free predictor of the mailbox. A table of
// directed accesses comes first, then segments of random traffic shaped to
// stream, fill, drain or mix the two queues. Both channels idle at random,
// and the response side holds off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dual_cpu_mailbox_fifo_sync_unit_tb;

   import dcmfs_pkg::*;

   localparam int QDEPTH        = MBX_DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS  = 1200;
   // The last stretch of random traffic runs with no idling on either side.
   localparam int TAIL_ITEMS    = 150;
   // The long hold-off on the response side starts once this many request
   // transfers have been taken, well before the quiet tail.
   localparam int HOLD_AFTER    = 500;
   localparam int LONG_HOLD     = 64;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int REPORT_LIMIT  = 10;

   // Operation codes the block must treat as no-ops.
   localparam logic [2:0] OP_UNUSED_6 = 3'd6;
   localparam logic [2:0] OP_UNUSED_7 = 3'd7;

   localparam logic MAIN   = 1'b0;
   localparam logic SECOND = 1'b1;

   // Write data bits for the control register.
   localparam logic [31:0] W_SEND_IE   = 32'h1 << CTL_SEND_IE;
   localparam logic [31:0] W_CLEAR     = 32'h1 << CTL_SEND_CLEAR;
   localparam logic [31:0] W_RECV_IE   = 32'h1 << CTL_RECV_IE;
   localparam logic [31:0] W_CLR_ERROR = 32'h1 << CTL_ERROR;
   localparam logic [31:0] W_ENABLE    = 32'h1 << CTL_ENABLE;
   localparam logic [31:0] W_SYNC_REQ  = 32'h1 << SYNC_IRQ_REQ;
   // Control register as read straight after reset: both queues empty.
   localparam logic [31:0] R_BOTH_EMPTY =
      (32'h1 << CTL_SEND_EMPTY) | (32'h1 << CTL_RECV_EMPTY);

   typedef struct packed {
      logic [31:0] read_data;
      logic [1:0]  irq_kind;
      logic        irq_target;
   } mbx_rsp_type;

   typedef struct packed {
      logic [2:0]  op;
      logic        side;
      logic [31:0] data;
      logic [4:0]  reps;
      logic        given;
      mbx_rsp_type rsp;
   } stim_row_type;

   typedef enum int {
      MODE_STREAM,
      MODE_FILL,
      MODE_MIXED,
      MODE_DRAIN
   } traffic_mode_type;

   localparam mbx_rsp_type ZERO_RSP = '{32'h0, IRQ_NONE, 1'b0};

   // Directed accesses. Where given is set, the response is typed in here;
   // otherwise it comes from the predictor. The predictor still follows
   // every row so that its state stays in step with the block.
   localparam int DIRECTED_COUNT = 25;
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // Register reads straight after reset.
      '{OP_SYNC_READ,  MAIN,   32'h0000_0000, 5'd1, 1'b1, ZERO_RSP},
      '{OP_CTRL_READ,  MAIN,   32'h0000_0000, 5'd1, 1'b1, '{R_BOTH_EMPTY, IRQ_NONE, 1'b0}},
      // Queues still disabled: the receive repeats the last word, the send
      // is dropped, and neither raises the error flag.
      '{OP_RECEIVE,    MAIN,   32'h0000_0000, 5'd1, 1'b1, ZERO_RSP},
      '{OP_SEND,       MAIN,   32'hFFFF_FFFF, 5'd1, 1'b1, ZERO_RSP},
      // Unused operation codes change nothing.
      '{OP_UNUSED_6,   SECOND, 32'hFFFF_FFFF, 5'd1, 1'b1, ZERO_RSP},
      '{OP_UNUSED_7,   MAIN,   32'hFFFF_FFFF, 5'd1, 1'b1, ZERO_RSP},
      // Enable both sides with both interrupts; the all-ones write also
      // clears an empty queue, which raises nothing.
      '{OP_CTRL_WRITE, SECOND, W_ENABLE | W_SEND_IE | W_RECV_IE,
                                              5'd1, 1'b1, ZERO_RSP},
      '{OP_CTRL_WRITE, MAIN,   32'hFFFF_FFFF, 5'd1, 1'b1, ZERO_RSP},
      // Sending into an empty queue tells the peer it has been filled.
      '{OP_SEND,       MAIN,   32'hFFFF_FFFF, 5'd1, 1'b1, '{32'h0, IRQ_RECV_FILLED, SECOND}},
      '{OP_SEND,       MAIN,   32'h0000_0000, 5'd1, 1'b0, ZERO_RSP},
      '{OP_CTRL_READ,  SECOND, 32'h0000_0000, 5'd1, 1'b0, ZERO_RSP},
      '{OP_RECEIVE,    SECOND, 32'h0000_0000, 5'd1, 1'b1, '{32'hFFFF_FFFF, IRQ_NONE, 1'b0}},
      // The receive that empties the queue tells the sender.
      '{OP_RECEIVE,    SECOND, 32'h0000_0000, 5'd1, 1'b1, '{32'h0, IRQ_SEND_EMPTY, MAIN}},
      // Receiving from an empty queue: error, last word repeated.
      '{OP_RECEIVE,    SECOND, 32'h0000_0000, 5'd1, 1'b1, ZERO_RSP},
      '{OP_CTRL_READ,  SECOND, 32'h0000_0000, 5'd1, 1'b0, ZERO_RSP},
      '{OP_CTRL_WRITE, SECOND, W_ENABLE | W_CLR_ERROR,
                                              5'd1, 1'b1, ZERO_RSP},
      // Sync: main accepts, secondary requests, then the other way round
      // once the main side has withdrawn its accept flag.
      '{OP_SYNC_WRITE, MAIN,   32'h0000_4F00, 5'd1, 1'b0, ZERO_RSP},
      '{OP_SYNC_WRITE, SECOND, 32'hFFFF_FFFF, 5'd1, 1'b1, '{32'h0, IRQ_SYNC, MAIN}},
      // Peer output 0xF, own output 0xF, own accept flag set.
      '{OP_SYNC_READ,  MAIN,   32'h0000_0000, 5'd1, 1'b1, '{32'h0000_4F0F, IRQ_NONE, 1'b0}},
      '{OP_SYNC_WRITE, MAIN,   W_SYNC_REQ,    5'd1, 1'b1, '{32'h0, IRQ_SYNC, SECOND}},
      '{OP_SYNC_WRITE, SECOND, W_SYNC_REQ,    5'd1, 1'b1, ZERO_RSP},
      // One more send than the queue holds: the last sets the error flag.
      '{OP_SEND,       SECOND, 32'hA5A5_5A5A, 5'(QDEPTH + 1), 1'b0, ZERO_RSP},
      '{OP_CTRL_READ,  SECOND, 32'h0000_0000, 5'd1, 1'b0, ZERO_RSP},
      // Clearing a non-empty queue with the send-empty enable just written.
      '{OP_CTRL_WRITE, SECOND, W_ENABLE | W_SEND_IE | W_CLEAR,
                                              5'd1, 1'b1, '{32'h0, IRQ_SEND_EMPTY, SECOND}},
      '{OP_RECEIVE,    MAIN,   32'h0000_0000, 5'd1, 1'b0, ZERO_RSP}
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_operation;
   logic        req_side;
   logic [31:0] req_write_data;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_read_data;
   logic [1:0]  rsp_irq_kind;
   logic        rsp_irq_target;

   // Predictor state: one queue per direction, queue n written by side n.
   logic [31:0]    queue_words [2][QDEPTH];
   int             queue_head [2];
   int             queue_fill [2];
   logic [3:0]     sync_out [2];
   side_flags_type flags [2];
   logic [31:0]    last_read [2];

   // Responses still owed by the block, oldest first.
   mbx_rsp_type awaited_rsp [$];
   mbx_rsp_type oldest;
   int          accepted_count = 0;
   int          failure_count = 0;
   int unsigned cycle_count = 0;
   logic        quiet_tail = 1'b0;
   logic        long_hold_done = 1'b0;

   dual_cpu_mailbox_fifo_sync_unit #(
      .MBX_DEPTH (QDEPTH)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_side       (req_side),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_data  (rsp_read_data),
      .rsp_irq_kind   (rsp_irq_kind),
      .rsp_irq_target (rsp_irq_target)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Applies one bus access to the predictor and returns the response it
   // owes. At most one interrupt is reported per access.
   function automatic mbx_rsp_type mailbox_access(input logic [2:0] op, input logic side,
                                                  input logic [31:0] wd);
      mbx_rsp_type    r;
      int             own;
      int             peer;
      side_flags_type f;
      logic           fill_from_zero;
      r = ZERO_RSP;
      own = side;
      peer = 1 - own;
      case (op)
         OP_SYNC_READ: begin
            r.read_data[SYNC_PEER_LSB +: 4] = sync_out[peer];
            r.read_data[SYNC_OWN_LSB +: 4] = sync_out[own];
            r.read_data[SYNC_ACCEPT] = flags[own].accept;
         end
         OP_SYNC_WRITE: begin
            sync_out[own] = wd[SYNC_OWN_LSB +: 4];
            flags[own].accept = wd[SYNC_ACCEPT];
            // The request bit is not stored; it only fires if the peer
            // has accepted sync interrupts.
            if (wd[SYNC_IRQ_REQ] && flags[peer].accept) begin
               r.irq_kind = IRQ_SYNC;
               r.irq_target = peer[0];
            end
         end
         OP_CTRL_READ: begin
            r.read_data[CTL_SEND_EMPTY] = (queue_fill[own] == 0);
            r.read_data[CTL_SEND_FULL] = (queue_fill[own] >= QDEPTH);
            r.read_data[CTL_SEND_IE] = flags[own].send_ie;
            r.read_data[CTL_RECV_EMPTY] = (queue_fill[peer] == 0);
            r.read_data[CTL_RECV_FULL] = (queue_fill[peer] >= QDEPTH);
            r.read_data[CTL_RECV_IE] = flags[own].recv_ie;
            r.read_data[CTL_ERROR] = flags[own].error;
            r.read_data[CTL_ENABLE] = flags[own].enable;
         end
         OP_CTRL_WRITE: begin
            f = flags[own];
            f.send_ie = wd[CTL_SEND_IE];
            f.recv_ie = wd[CTL_RECV_IE];
            f.enable = wd[CTL_ENABLE];
            if (wd[CTL_ERROR]) begin
               f.error = 1'b0;
            end
            flags[own] = f;
            if (wd[CTL_SEND_CLEAR]) begin
               if (queue_fill[own] != 0 && f.send_ie) begin
                  r.irq_kind = IRQ_SEND_EMPTY;
                  r.irq_target = own[0];
               end
               queue_head[own] = 0;
               queue_fill[own] = 0;
            end
         end
         OP_SEND: begin
            if (flags[own].enable) begin
               if (queue_fill[own] >= QDEPTH) begin
                  flags[own].error = 1'b1;
               end else begin
                  fill_from_zero = (queue_fill[own] == 0);
                  queue_words[own][(queue_head[own] + queue_fill[own]) % QDEPTH] = wd;
                  queue_fill[own]++;
                  if (fill_from_zero && flags[peer].recv_ie) begin
                     r.irq_kind = IRQ_RECV_FILLED;
                     r.irq_target = peer[0];
                  end
               end
            end
         end
         OP_RECEIVE: begin
            // A side receives from the queue that its peer sends into.
            if (flags[own].enable && queue_fill[peer] == 0) begin
               flags[own].error = 1'b1;
            end else if (flags[own].enable) begin
               last_read[own] = queue_words[peer][queue_head[peer]];
               queue_head[peer] = (queue_head[peer] + 1) % QDEPTH;
               queue_fill[peer]--;
               if (queue_fill[peer] == 0 && flags[peer].send_ie) begin
                  r.irq_kind = IRQ_SEND_EMPTY;
                  r.irq_target = peer[0];
               end
            end
            r.read_data = last_read[own];
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // Offers one access and holds it until the block takes it, then records
   // the response it owes. Returns at the edge of the transfer.
   task automatic issue(input logic [2:0] op, input logic side, input logic [31:0] wd,
                        input logic given, input mbx_rsp_type given_rsp);
      mbx_rsp_type predicted;
      req_valid <= 1'b1;
      req_operation <= op;
      req_side <= side;
      req_write_data <= wd;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predicted = mailbox_access(op, side, wd);
      awaited_rsp.push_back(given ? given_rsp : predicted);
      accepted_count++;
   endtask

   // Sender gaps: short bursts with valid low, none in the quiet tail.
   task automatic maybe_idle();
      if (!quiet_tail && $urandom_range(0, 9) < 2) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // Picks one random access for the given traffic shape. Streaming moves
   // words from the lead side to its peer, filling pushes the lead side's
   // queue towards full, draining favours receives, and mixed traffic
   // touches every operation including the unused codes.
   task automatic pick_access(input traffic_mode_type mode, input logic lead,
                              output logic [2:0] op, output logic side,
                              output logic [31:0] wd);
      int roll;
      roll = $urandom_range(0, 99);
      side = 1'($urandom_range(0, 1));
      op = 3'($urandom_range(OP_SYNC_READ, OP_RECEIVE));
      case (mode)
         MODE_STREAM: begin
            if (roll < 55) begin
               op = OP_SEND;
               side = lead;
            end else if (roll < 85) begin
               op = OP_RECEIVE;
               side = ~lead;
            end
         end
         MODE_FILL: begin
            if (roll < 85) begin
               op = OP_SEND;
               side = lead;
            end
         end
         MODE_DRAIN: begin
            if (roll < 70) begin
               op = OP_RECEIVE;
            end
         end
         default: begin
            if (roll < 8) begin
               op = roll[0] ? OP_UNUSED_6 : OP_UNUSED_7;
            end
         end
      endcase
      wd = $urandom;
      // Control writes mostly keep the queues enabled and rarely clear
      // them, so that the queues get deep enough to reach full.
      if (op == OP_CTRL_WRITE) begin
         if ($urandom_range(0, 9) != 0) begin
            wd[CTL_ENABLE] = 1'b1;
         end
         if ($urandom_range(0, 7) != 0) begin
            wd[CTL_SEND_CLEAR] = 1'b0;
         end
      end
   endtask

   task automatic report_failure(input string what);
      failure_count++;
      if (failure_count <= REPORT_LIMIT) begin
         $display("mismatch %0d at %0t ns: %s", failure_count, $realtime, what);
      end
   endtask

   // Response checking. A response transfer happens at an edge where valid
   // is high and our stall is low; both are sampled before this edge's
   // updates land, so the check does not race the driving processes.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (awaited_rsp.size() == 0) begin
            report_failure($sformatf("response with none awaited: data %h kind %0d target %0d",
                                     rsp_read_data, rsp_irq_kind, rsp_irq_target));
         end else begin
            oldest = awaited_rsp.pop_front();
            if (rsp_read_data !== oldest.read_data || rsp_irq_kind !== oldest.irq_kind ||
                rsp_irq_target !== oldest.irq_target) begin
               report_failure($sformatf({"expected data %h kind %0d target %0d, ",
                                         "got data %h kind %0d target %0d"},
                                        oldest.read_data, oldest.irq_kind, oldest.irq_target,
                                        rsp_read_data, rsp_irq_kind, rsp_irq_target));
            end
         end
      end
   end

   // Watchdog: a run that hangs on a handshake ends here as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Response side. Random stall bursts and calm stretches, plus one long
   // hold-off while the sender keeps offering, so that the held response
   // backs up into the request channel. The hold is counted here, in
   // cycles, independently of the sender.
   initial begin
      int roll;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         roll = $urandom_range(0, 9);
         if (!long_hold_done && accepted_count >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet_tail && roll < 3) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (roll == 3) begin
            repeat ($urandom_range(10, 40)) @(posedge clock);
         end
      end
   end

   // Request side: reset, the directed table, then random traffic in
   // segments of one shape each, and finally the drain.
   initial begin
      traffic_mode_type seg_mode;
      logic             lead;
      int               seg_len;
      int               n;
      logic [2:0]       op;
      logic             side;
      logic [31:0]      wd;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_operation <= OP_SYNC_READ;
      req_side <= MAIN;
      req_write_data <= 32'h0;
      for (int s = 0; s < 2; s++) begin
         queue_head[s] = 0;
         queue_fill[s] = 0;
         sync_out[s] = 4'h0;
         flags[s] = '0;
         last_read[s] = 32'h0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_ROWS[i]) begin
         for (int k = 0; k < DIRECTED_ROWS[i].reps; k++) begin
            issue(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].side, DIRECTED_ROWS[i].data,
                  DIRECTED_ROWS[i].given, DIRECTED_ROWS[i].rsp);
            maybe_idle();
         end
      end

      n = 0;
      while (n < RANDOM_ITEMS) begin
         seg_mode = traffic_mode_type'($urandom_range(MODE_STREAM, MODE_DRAIN));
         lead = 1'($urandom_range(0, 1));
         seg_len = $urandom_range(8, 40);
         for (int k = 0; k < seg_len && n < RANDOM_ITEMS; k++) begin
            quiet_tail = (n >= RANDOM_ITEMS - TAIL_ITEMS);
            pick_access(seg_mode, lead, op, side, wd);
            issue(op, side, wd, 1'b0, ZERO_RSP);
            maybe_idle();
            n++;
         end
      end
      req_valid <= 1'b0;

      // Every access owes exactly one response, so once none is awaited
      // only a stray extra response could still appear; the run waits on
      // for it to show itself.
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (failure_count == 0 && awaited_rsp.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
